// ----- rtl/core/vertical_altitude_kalman_filter_macros.svh -----
// Assertion macros shared by the altitude filter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef VERTICAL_ALTITUDE_KALMAN_FILTER_MACROS_SVH
`define VERTICAL_ALTITUDE_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VAKF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VAKF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/vakf_pkg.sv -----
// Shared types, constants and saturating helpers for the altitude filter.
// No dependencies; used by vakf_mul_shift and the top level.
`timescale 1ns / 1ps
`default_nettype none

package vakf_pkg;

    typedef logic signed [63:0] t_s64;
    typedef logic signed [31:0] t_s32;
    typedef logic [1:0]         t_cmd;

    // Command codes carried in the input tuser.
    localparam t_cmd CMD_INIT    = 2'd0;
    localparam t_cmd CMD_PREDICT = 2'd1;
    localparam t_cmd CMD_BARO    = 2'd2;

    // Configuration register indexes.
    localparam logic [0:0] CFG_ACCEL_VAR = 1'b0;
    localparam logic [0:0] CFG_BARO_VAR  = 1'b1;

    localparam logic [31:0] VAR_RESET  = 32'd65536;
    localparam t_s64        SKIP_LIMIT = 64'sd17;
    localparam t_s64        COV_ONE    = 64'sd16777216;

    // Request to the shared multiply-and-round unit.
    typedef struct packed {
        logic               start;
        t_s64               a;
        logic signed [33:0] b;
        logic [4:0]         s;
    } t_mul_req;

    // Status and result of the shared multiply-and-round unit.
    typedef struct packed {
        logic busy;
        logic done;
        t_s64 result;
    } t_mul_rsp;

    function automatic t_s64 add_sat(t_s64 a, t_s64 b);
        logic signed [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) begin
            return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return sum[63:0];
    endfunction

    function automatic t_s64 sub_sat(t_s64 a, t_s64 b);
        logic signed [64:0] dif;
        dif = {a[63], a} - {b[63], b};
        if (dif[64] != dif[63]) begin
            return dif[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return dif[63:0];
    endfunction

    function automatic t_s32 sat32(t_s64 x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vakf_mul_shift.sv -----
// Shared multiply-and-round unit: round(a*b/2^s), ties up, saturated to 64 bits.
// Uses one 34x34 signed multiplier across its phases; depends on vakf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vakf_mul_shift (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vakf_pkg::t_mul_req i_req,
    output vakf_pkg::t_mul_rsp     o_rsp
);

    logic [1:0]          r_phase;
    logic                r_busy;
    logic                r_done;
    vakf_pkg::t_s64      r_hi;
    logic [23:0]         r_lo;
    logic signed [33:0]  r_b;
    logic [4:0]          r_s;
    logic signed [99:0]  r_acc;
    vakf_pkg::t_s64      r_hb;
    vakf_pkg::t_s64      r_frac;
    vakf_pkg::t_s64      r_result;

    logic signed [33:0]  w_ma;
    logic signed [67:0]  w_prod;
    logic signed [67:0]  w_fsum;
    logic signed [67:0]  w_frac;
    logic [23:0]         w_mask;

    // The multiplier sees the low half of the integer part, then the high half,
    // then the fraction that the shift drops.
    always_comb begin
        case (r_phase)
            2'd0:    w_ma = {2'b00, r_hi[31:0]};
            2'd1:    w_ma = {{2{r_hi[63]}}, r_hi[63:32]};
            default: w_ma = {10'd0, r_lo};
        endcase
    end

    assign w_prod = w_ma * r_b;
    assign w_fsum = w_prod + (68'sd1 <<< (r_s - 5'd1));
    assign w_frac = w_fsum >>> r_s;
    assign w_mask = (24'd1 << i_req.s) - 24'd1;

    // Phase sequencer and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            // The done pulse lasts one cycle; the unit is idle while it is high.
            if (r_done) begin
                r_done <= 1'b0;
            end
            if (i_req.start && !r_busy) begin
                r_hi    <= i_req.a >>> i_req.s;
                r_lo    <= i_req.a[23:0] & w_mask;
                r_b     <= i_req.b;
                r_s     <= i_req.s;
                r_phase <= 2'd0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                case (r_phase)
                    2'd0: begin
                        r_acc <= {{32{w_prod[67]}}, w_prod};
                    end
                    2'd1: begin
                        r_acc <= r_acc + {w_prod, 32'd0};
                    end
                    2'd2: begin
                        r_frac <= w_frac[63:0];
                        if ((&r_acc[99:63]) || !(|r_acc[99:63])) begin
                            r_hb <= r_acc[63:0];
                        end else begin
                            r_hb <= r_acc[99] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        end
                    end
                    default: begin
                        r_result <= vakf_pkg::add_sat(r_hb, r_frac);
                        r_done   <= 1'b1;
                        r_busy   <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

`default_nettype wire

// ----- rtl/core/vertical_altitude_kalman_filter.sv -----
// Predict makes 13 passes through the multiply-and-round unit; a baro update
// runs two gain divisions plus 6 multiply passes, unless it is skipped, in which
// case it goes straight to the output stage, as do initialize and the unused
// command. One item at a time: a new input is taken only once the previous result
// has reached the output register. Reset (synchronous, active low)
// restores state and variances at once; the covariance resets to identity.
// Top level of the two-state altitude/velocity filter; depends on vakf_pkg,
// vakf_mul_shift and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vertical_altitude_kalman_filter_macros.svh"

module vertical_altitude_kalman_filter #(
    parameter int COVARIANCE_BITS = 48
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // accel_vertical[31:0], time_step[47:32], altitude_in[79:48], velocity_in[111:80]
    input  wire logic [111:0] s_axis_tdata,
    // command[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // altitude_est[31:0], velocity_est[63:32], accel_last[95:64]
    output logic [95:0]       m_axis_tdata,
    // update_skipped[0]
    output logic [0:0]        m_axis_tuser,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    localparam int CB = COVARIANCE_BITS;
    localparam vakf_pkg::t_s64 COV_MAX = (64'sd1 <<< (CB - 1)) - 64'sd1;
    localparam vakf_pkg::t_s64 COV_MIN = -COV_MAX - 64'sd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_ADT, S_P_VDT, S_P_ADT2, S_P_S1, S_P_S2, S_P_S3, S_P_Q01, S_P_S4, S_P_Q00,
        S_P_E, S_P_CVH, S_P_CHV, S_P_EDT, S_P_FIN1, S_P_FIN2,
        S_B_SUM, S_B_DINIT, S_B_DIV, S_B_DEND, S_B_INNOV,
        S_B_H, S_B_V, S_B_C10, S_B_C11, S_B_C00, S_B_C01,
        S_DONE
    } t_state;

    function automatic vakf_pkg::t_s64 cov_clamp(vakf_pkg::t_s64 x);
        if (x > COV_MAX) begin
            return COV_MAX;
        end
        if (x < COV_MIN) begin
            return COV_MIN;
        end
        return x;
    endfunction

    t_state                r_state;
    logic                  r_go;
    logic [31:0]           r_accel_var;
    logic [31:0]           r_baro_var;
    vakf_pkg::t_s32        r_height;
    vakf_pkg::t_s32        r_velocity;
    vakf_pkg::t_s32        r_last_accel;
    logic signed [CB-1:0]  r_cov_hh;
    logic signed [CB-1:0]  r_cov_hv;
    logic signed [CB-1:0]  r_cov_vh;
    logic signed [CB-1:0]  r_cov_vv;
    vakf_pkg::t_cmd        r_cmd;
    vakf_pkg::t_s32        r_accel;
    logic [15:0]           r_dt;
    vakf_pkg::t_s32        r_alt;
    vakf_pkg::t_s64        r_adt;
    vakf_pkg::t_s64        r_t1;
    vakf_pkg::t_s64        r_sn;
    vakf_pkg::t_s64        r_q11;
    vakf_pkg::t_s64        r_q01;
    vakf_pkg::t_s64        r_q00;
    vakf_pkg::t_s64        r_e;
    vakf_pkg::t_s64        r_acc;
    logic [63:0]           r_den;
    logic [63:0]           r_rem;
    logic [30:0]           r_nbits;
    logic [30:0]           r_q;
    logic [4:0]            r_cnt;
    logic                  r_neg;
    logic                  r_kidx;
    vakf_pkg::t_s32        r_k0;
    vakf_pkg::t_s32        r_k1;
    vakf_pkg::t_s32        r_innov;
    logic                  r_skip;
    logic                  r_out_valid;
    logic [95:0]           r_out_data;
    logic                  r_out_skip;

    vakf_pkg::t_mul_req    w_req;
    vakf_pkg::t_mul_rsp    w_rsp;
    vakf_pkg::t_s64        w_p00;
    vakf_pkg::t_s64        w_p01;
    vakf_pkg::t_s64        w_p10;
    vakf_pkg::t_s64        w_p11;
    vakf_pkg::t_s64        w_h;
    vakf_pkg::t_s64        w_v;
    vakf_pkg::t_s64        w_res;
    logic signed [33:0]    w_bdt;
    vakf_pkg::t_s64        w_ssum;
    vakf_pkg::t_s64        w_num;
    logic [63:0]           w_nabs;
    logic [63:0]           w_trial;
    vakf_pkg::t_s32        w_k;
    logic                  w_accept;

    assign w_p00 = 64'(r_cov_hh);
    assign w_p01 = 64'(r_cov_hv);
    assign w_p10 = 64'(r_cov_vh);
    assign w_p11 = 64'(r_cov_vv);
    assign w_h   = 64'(r_height);
    assign w_v   = 64'(r_velocity);
    assign w_res = w_rsp.result;
    assign w_bdt = {18'd0, r_dt};

    assign w_ssum  = vakf_pkg::add_sat(w_p00, {24'd0, r_baro_var, 8'd0});
    assign w_num   = r_kidx ? w_p10 : w_p00;
    assign w_nabs  = w_num[63] ? (64'd0 - w_num) : w_num;
    assign w_trial = {r_rem[62:0], r_nbits[30]};
    assign w_k     = r_neg ? (32'sd0 - $signed({1'b0, r_q})) : $signed({1'b0, r_q});

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Operand selection for the shared multiply-and-round unit.
    always_comb begin
        w_req.start = r_go;
        w_req.a     = w_p00;
        w_req.b     = w_bdt;
        w_req.s     = 5'd16;
        case (r_state)
            S_P_ADT:  w_req.a = 64'(r_accel);
            S_P_VDT:  w_req.a = w_v;
            S_P_ADT2: begin
                w_req.a = r_adt;
                w_req.s = 5'd17;
            end
            S_P_S1:   w_req.a = {24'd0, r_accel_var, 8'd0};
            S_P_S2,
            S_P_S3,
            S_P_S4:   w_req.a = r_sn;
            S_P_Q01: begin
                w_req.a = r_sn;
                w_req.b = 34'sd1;
                w_req.s = 5'd1;
            end
            S_P_Q00: begin
                w_req.a = r_sn;
                w_req.b = 34'sd1;
                w_req.s = 5'd2;
            end
            S_P_E:    w_req.a = w_p11;
            S_P_CVH:  w_req.a = w_p10;
            S_P_CHV:  w_req.a = w_p01;
            S_P_EDT:  w_req.a = r_e;
            S_B_H: begin
                w_req.a = 64'(r_innov);
                w_req.b = 34'(r_k0);
                w_req.s = 5'd24;
            end
            S_B_V: begin
                w_req.a = 64'(r_innov);
                w_req.b = 34'(r_k1);
                w_req.s = 5'd24;
            end
            S_B_C10: begin
                w_req.a = w_p00;
                w_req.b = 34'(r_k1);
                w_req.s = 5'd24;
            end
            S_B_C11: begin
                w_req.a = w_p01;
                w_req.b = 34'(r_k1);
                w_req.s = 5'd24;
            end
            S_B_C00: begin
                w_req.a = w_p00;
                w_req.b = 34'(r_k0);
                w_req.s = 5'd24;
            end
            S_B_C01: begin
                w_req.a = w_p01;
                w_req.b = 34'(r_k0);
                w_req.s = 5'd24;
            end
            default: w_req.a = w_p00;
        endcase
    end

    vakf_mul_shift u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Sequencer, filter state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_go         <= 1'b0;
            r_accel_var  <= vakf_pkg::VAR_RESET;
            r_baro_var   <= vakf_pkg::VAR_RESET;
            r_height     <= '0;
            r_velocity   <= '0;
            r_last_accel <= '0;
            r_cov_hh     <= CB'(vakf_pkg::COV_ONE);
            r_cov_hv     <= '0;
            r_cov_vh     <= '0;
            r_cov_vv     <= CB'(vakf_pkg::COV_ONE);
            r_out_valid  <= 1'b0;
            r_skip       <= 1'b0;
            r_kidx       <= 1'b0;
            r_cnt        <= '0;
        end else begin
            // The start strobe lasts one cycle; no state raises it while it is high.
            if (r_go) begin
                r_go <= 1'b0;
            end

            // Register writes must arrive only while the filter is idle; the block does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    vakf_pkg::CFG_ACCEL_VAR: r_accel_var <= i_cfg_data;
                    vakf_pkg::CFG_BARO_VAR:  r_baro_var  <= i_cfg_data;
                    default: ;
                endcase
            end

            // A new output beat loads from S_DONE; otherwise the beat leaves
            // when the sink takes it.
            if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= s_axis_tuser;
                        r_accel <= s_axis_tdata[31:0];
                        r_dt    <= s_axis_tdata[47:32];
                        r_alt   <= s_axis_tdata[79:48];
                        r_skip  <= 1'b0;
                        case (s_axis_tuser)
                            vakf_pkg::CMD_INIT: begin
                                r_height     <= s_axis_tdata[79:48];
                                r_velocity   <= s_axis_tdata[111:80];
                                r_last_accel <= '0;
                                r_cov_hh     <= CB'(vakf_pkg::COV_ONE);
                                r_cov_hv     <= '0;
                                r_cov_vh     <= '0;
                                r_cov_vv     <= CB'(vakf_pkg::COV_ONE);
                                r_state      <= S_DONE;
                            end
                            vakf_pkg::CMD_PREDICT: begin
                                r_state <= S_P_ADT;
                                r_go    <= 1'b1;
                            end
                            vakf_pkg::CMD_BARO: r_state <= S_B_SUM;
                            default:            r_state <= S_DONE;
                        endcase
                    end
                end

                // Kinematics of predict.
                S_P_ADT: if (w_rsp.done) begin
                    r_adt   <= w_res;
                    r_state <= S_P_VDT;
                    r_go    <= 1'b1;
                end
                S_P_VDT: if (w_rsp.done) begin
                    r_t1    <= w_res;
                    r_state <= S_P_ADT2;
                    r_go    <= 1'b1;
                end
                S_P_ADT2: if (w_rsp.done) begin
                    r_height     <= vakf_pkg::sat32(w_h + r_t1 + w_res);
                    r_velocity   <= vakf_pkg::sat32(w_v + r_adt);
                    r_last_accel <= r_accel;
                    r_state      <= S_P_S1;
                    r_go         <= 1'b1;
                end

                // Process noise powers of the time step.
                S_P_S1: if (w_rsp.done) begin
                    r_sn    <= w_res;
                    r_state <= S_P_S2;
                    r_go    <= 1'b1;
                end
                S_P_S2: if (w_rsp.done) begin
                    r_sn    <= w_res;
                    r_q11   <= w_res;
                    r_state <= S_P_S3;
                    r_go    <= 1'b1;
                end
                S_P_S3: if (w_rsp.done) begin
                    r_sn    <= w_res;
                    r_state <= S_P_Q01;
                    r_go    <= 1'b1;
                end
                S_P_Q01: if (w_rsp.done) begin
                    r_q01   <= w_res;
                    r_state <= S_P_S4;
                    r_go    <= 1'b1;
                end
                S_P_S4: if (w_rsp.done) begin
                    r_sn    <= w_res;
                    r_state <= S_P_Q00;
                    r_go    <= 1'b1;
                end
                S_P_Q00: if (w_rsp.done) begin
                    r_q00   <= w_res;
                    r_state <= S_P_E;
                    r_go    <= 1'b1;
                end

                // Covariance propagation.
                S_P_E: if (w_rsp.done) begin
                    r_e     <= w_res;
                    r_state <= S_P_CVH;
                    r_go    <= 1'b1;
                end
                S_P_CVH: if (w_rsp.done) begin
                    r_acc   <= vakf_pkg::add_sat(w_p00, w_res);
                    r_state <= S_P_CHV;
                    r_go    <= 1'b1;
                end
                S_P_CHV: if (w_rsp.done) begin
                    r_acc   <= vakf_pkg::add_sat(r_acc, w_res);
                    r_state <= S_P_EDT;
                    r_go    <= 1'b1;
                end
                S_P_EDT: if (w_rsp.done) begin
                    r_acc   <= vakf_pkg::add_sat(r_acc, w_res);
                    r_state <= S_P_FIN1;
                end
                S_P_FIN1: begin
                    r_acc   <= vakf_pkg::add_sat(r_acc, cov_clamp(r_q00));
                    r_q01   <= cov_clamp(r_q01);
                    r_q11   <= cov_clamp(r_q11);
                    r_t1    <= vakf_pkg::add_sat(w_p01, r_e);
                    r_adt   <= vakf_pkg::add_sat(w_p10, r_e);
                    r_state <= S_P_FIN2;
                end
                S_P_FIN2: begin
                    r_cov_hh <= CB'(cov_clamp(r_acc));
                    r_cov_hv <= CB'(cov_clamp(vakf_pkg::add_sat(r_t1, r_q01)));
                    r_cov_vh <= CB'(cov_clamp(vakf_pkg::add_sat(r_adt, r_q01)));
                    r_cov_vv <= CB'(cov_clamp(vakf_pkg::add_sat(w_p11, r_q11)));
                    r_state  <= S_DONE;
                end

                // Innovation variance and the skip test.
                S_B_SUM: begin
                    if (w_ssum < vakf_pkg::SKIP_LIMIT) begin
                        r_skip  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_den   <= w_ssum;
                        r_kidx  <= 1'b0;
                        r_state <= S_B_DINIT;
                    end
                end

                // Gain division: restoring, one quotient bit a cycle.
                S_B_DINIT: begin
                    r_neg   <= w_num[63];
                    r_rem   <= {7'd0, w_nabs[63:7]};
                    r_nbits <= {w_nabs[6:0], 24'd0};
                    r_cnt   <= '0;
                    if ({7'd0, w_nabs[63:7]} >= r_den) begin
                        r_q     <= {31{1'b1}};
                        r_state <= S_B_DEND;
                    end else begin
                        r_state <= S_B_DIV;
                    end
                end
                S_B_DIV: begin
                    if (w_trial >= r_den) begin
                        r_rem <= w_trial - r_den;
                        r_q   <= {r_q[29:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_q   <= {r_q[29:0], 1'b0};
                    end
                    r_nbits <= {r_nbits[29:0], 1'b0};
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_state <= S_B_DEND;
                    end
                end
                S_B_DEND: begin
                    if (!r_kidx) begin
                        r_k0    <= w_k;
                        r_kidx  <= 1'b1;
                        r_state <= S_B_DINIT;
                    end else begin
                        r_k1    <= w_k;
                        r_state <= S_B_INNOV;
                    end
                end

                // State and covariance correction; old covariance entries are
                // read before they are overwritten.
                S_B_INNOV: begin
                    r_innov <= vakf_pkg::sat32(64'(r_alt) - w_h);
                    r_state <= S_B_H;
                    r_go    <= 1'b1;
                end
                S_B_H: if (w_rsp.done) begin
                    r_height <= vakf_pkg::sat32(w_h + w_res);
                    r_state  <= S_B_V;
                    r_go     <= 1'b1;
                end
                S_B_V: if (w_rsp.done) begin
                    r_velocity <= vakf_pkg::sat32(w_v + w_res);
                    r_state    <= S_B_C10;
                    r_go       <= 1'b1;
                end
                S_B_C10: if (w_rsp.done) begin
                    r_cov_vh <= CB'(cov_clamp(vakf_pkg::sub_sat(w_p10, w_res)));
                    r_state  <= S_B_C11;
                    r_go     <= 1'b1;
                end
                S_B_C11: if (w_rsp.done) begin
                    r_cov_vv <= CB'(cov_clamp(vakf_pkg::sub_sat(w_p11, w_res)));
                    r_state  <= S_B_C00;
                    r_go     <= 1'b1;
                end
                S_B_C00: if (w_rsp.done) begin
                    r_cov_hh <= CB'(cov_clamp(vakf_pkg::sub_sat(w_p00, w_res)));
                    r_state  <= S_B_C01;
                    r_go     <= 1'b1;
                end
                S_B_C01: if (w_rsp.done) begin
                    r_cov_hv <= CB'(cov_clamp(vakf_pkg::sub_sat(w_p01, w_res)));
                    r_state  <= S_DONE;
                end

                // Hand the result to the output register once it is free.
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= {r_last_accel, r_velocity, r_height};
                        r_out_skip  <= r_skip;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_skip;

    // Design checks.
    `VAKF_ASSERT_IMP(a_go_free, i_clk, i_rst_n, r_go, !w_rsp.busy, "mul start while unit busy")
    `VAKF_ASSERT_NXT(a_predict_start, i_clk, i_rst_n, w_accept && (s_axis_tuser == vakf_pkg::CMD_PREDICT), (r_state == S_P_ADT) && r_go, "predict did not start multiply")
    `VAKF_ASSERT_IMP(a_div_count, i_clk, i_rst_n, r_state == S_B_DIV, r_cnt <= 5'd30, "divider ran past its bit count")
    `VAKF_ASSERT_IMP(a_skip_baro, i_clk, i_rst_n, (r_state == S_DONE) && r_skip, r_cmd == vakf_pkg::CMD_BARO, "skip flag on a non-baro command")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the vertical altitude Kalman filter.
// Depends on vakf_pkg and the vertical_altitude_kalman_filter RTL.
`timescale 1ns / 1ps

module testbench;

    localparam vakf_pkg::t_cmd CMD_UNUSED = 2'd3;
    localparam int             COV_BITS   = 48;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // accel_vertical[31:0], time_step[47:32], altitude_in[79:48], velocity_in[111:80]
    logic [111:0] s_axis_tdata;
    // command[1:0]
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // altitude_est[31:0], velocity_est[63:32], accel_last[95:64]
    logic [95:0]  m_axis_tdata;
    // update_skipped[0]
    logic [0:0]   m_axis_tuser;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    vertical_altitude_kalman_filter #(.COVARIANCE_BITS(COV_BITS)) i_dut (.*);

    typedef struct packed {
        logic [31:0] altitude;
        logic [31:0] velocity;
        logic [31:0] accel;
        logic        skipped;
    } t_estimate;

    t_estimate estimate_q[$];
    int        error_count = 0;
    bit        idle_off = 0;

    // Predictor state: kinematics, covariance and the two noise variances.
    longint      est_h, est_v, est_a;
    longint      p_hh, p_hv, p_vh, p_vv;
    logic [31:0] accel_var, baro_var;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Saturating 64-bit helpers.
    function automatic longint sum_sat(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic longint prod_sat(longint a, longint b);
        logic signed [127:0] x, y, p;
        x = a;
        y = b;
        p = x * y;
        if (p > 128'sh7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        if (p < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return p[63:0];
    endfunction

    // round(a*b/2^s), ties toward +infinity, split so the low part is exact.
    function automatic longint scale_round(longint a, longint b, int s);
        longint hi, lo, frac;
        hi = a >>> s;
        lo = a - (hi <<< s);
        frac = (lo * b + (64'sd1 <<< (s - 1))) >>> s;
        return sum_sat(prod_sat(hi, b), frac);
    endfunction

    function automatic longint clip_cov(longint x);
        longint mx;
        mx = (64'sd1 <<< (COV_BITS - 1)) - 1;
        return x > mx ? mx : (x < -mx - 1 ? -mx - 1 : x);
    endfunction

    function automatic longint clip32(longint x);
        return x > 64'sd2147483647 ? 64'sd2147483647 :
               (x < -64'sd2147483648 ? -64'sd2147483648 : x);
    endfunction

    // Kalman gain num/den in Q8.24, truncated toward zero.
    function automatic longint kgain(longint num, longint den);
        longint unsigned n, d, q, r;
        n = num < 0 ? -num : num;
        d = den;
        q = n / d;
        r = n % d;
        if (q >= 128) q = 64'd2147483647;
        else begin
            for (int i = 0; i < 24; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
            end
            if (q > 64'd2147483647) q = 64'd2147483647;
        end
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic reset_filter_state();
        est_h = 0;
        est_v = 0;
        est_a = 0;
        p_hh = 64'sd16777216;
        p_hv = 0;
        p_vh = 0;
        p_vv = 64'sd16777216;
    endtask

    // Advance the predicted filter by one command and return its output beat.
    function automatic t_estimate filter_step(vakf_pkg::t_cmd cmd, logic [31:0] acc,
                                              logic [15:0] dt_u,
                                              logic [31:0] alt, logic [31:0] vel);
        t_estimate r;
        longint a, dt, adt, sig, s1, s2, s3, s4, q00, q01, q11, e, n00, n01, n10, n11;
        longint sv, k0, k1, innov, o_hh, o_hv, o_vh, o_vv;
        r.skipped = 1'b0;
        a = longint'($signed(acc));
        dt = longint'(dt_u);
        case (cmd)
            vakf_pkg::CMD_INIT: begin
                est_h = longint'($signed(alt));
                est_v = longint'($signed(vel));
                est_a = 0;
                p_hh = 64'sd16777216;
                p_hv = 0;
                p_vh = 0;
                p_vv = 64'sd16777216;
            end
            vakf_pkg::CMD_PREDICT: begin
                adt = scale_round(a, dt, 16);
                est_h = clip32(est_h + scale_round(est_v, dt, 16) + scale_round(adt, dt, 17));
                est_v = clip32(est_v + adt);
                sig = longint'(accel_var) << 8;
                s1 = scale_round(sig, dt, 16);
                s2 = scale_round(s1, dt, 16);
                s3 = scale_round(s2, dt, 16);
                s4 = scale_round(s3, dt, 16);
                q11 = clip_cov(s2);
                q01 = clip_cov(scale_round(s3, 1, 1));
                q00 = clip_cov(scale_round(s4, 1, 2));
                e = scale_round(p_vv, dt, 16);
                n00 = sum_sat(p_hh, scale_round(p_vh, dt, 16));
                n00 = sum_sat(n00, scale_round(p_hv, dt, 16));
                n00 = sum_sat(n00, scale_round(e, dt, 16));
                n00 = sum_sat(n00, q00);
                n01 = sum_sat(sum_sat(p_hv, e), q01);
                n10 = sum_sat(sum_sat(p_vh, e), q01);
                n11 = sum_sat(p_vv, q11);
                p_hh = clip_cov(n00);
                p_hv = clip_cov(n01);
                p_vh = clip_cov(n10);
                p_vv = clip_cov(n11);
                est_a = a;
            end
            vakf_pkg::CMD_BARO: begin
                sv = sum_sat(p_hh, longint'(baro_var) << 8);
                if (sv < 17) r.skipped = 1'b1;
                else begin
                    k0 = kgain(p_hh, sv);
                    k1 = kgain(p_vh, sv);
                    innov = clip32(longint'($signed(alt)) - est_h);
                    est_h = clip32(est_h + scale_round(innov, k0, 24));
                    est_v = clip32(est_v + scale_round(innov, k1, 24));
                    o_hh = p_hh;
                    o_hv = p_hv;
                    o_vh = p_vh;
                    o_vv = p_vv;
                    p_hh = clip_cov(sum_sat(o_hh, -scale_round(o_hh, k0, 24)));
                    p_hv = clip_cov(sum_sat(o_hv, -scale_round(o_hv, k0, 24)));
                    p_vh = clip_cov(sum_sat(o_vh, -scale_round(o_hh, k1, 24)));
                    p_vv = clip_cov(sum_sat(o_vv, -scale_round(o_hv, k1, 24)));
                end
            end
            default: ;
        endcase
        r.altitude = est_h[31:0];
        r.velocity = est_v[31:0];
        r.accel = est_a[31:0];
        return r;
    endfunction

    // Gap length: mostly short, a few long, none while idle_off is set.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side backpressure.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest predicted estimate.
    always @(posedge i_clk) begin
        t_estimate want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (estimate_q.size() == 0) begin
                $display("%0t: unexpected beat %h / %b", $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = estimate_q.pop_front();
                if (m_axis_tdata[31:0] !== want.altitude) begin
                    $display("%0t: altitude expected %h actual %h", $time, want.altitude,
                             m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== want.velocity) begin
                    $display("%0t: velocity expected %h actual %h", $time, want.velocity,
                             m_axis_tdata[63:32]);
                    error_count++;
                end
                if (m_axis_tdata[95:64] !== want.accel) begin
                    $display("%0t: accel expected %h actual %h", $time, want.accel,
                             m_axis_tdata[95:64]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.skipped) begin
                    $display("%0t: skipped expected %b actual %b", $time, want.skipped,
                             m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // Send one input beat; valid stays high into the next beat when there is no gap.
    task automatic send_item(vakf_pkg::t_cmd cmd, logic [31:0] acc, logic [15:0] dt,
                             logic [31:0] alt, logic [31:0] vel);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {vel, alt, dt, acc};
        do @(posedge i_clk); while (!s_axis_tready);
        estimate_q.push_back(filter_step(cmd, acc, dt, alt, vel));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (estimate_q.size() != 0) @(posedge i_clk);
    endtask

    // Registers are written only once the filter has gone quiet.
    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == vakf_pkg::CFG_ACCEL_VAR) accel_var = value;
        else baro_var = value;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_item(CMD_UNUSED, $urandom, 16'($urandom), $urandom, $urandom);
        send_item(vakf_pkg::CMD_BARO, 32'h0001_0000, 16'h0, 32'h0005_0000, 32'h0);
        send_item(vakf_pkg::CMD_PREDICT, 32'h0002_0000, 16'h1000, 32'h0, 32'h0);
    endtask

    task automatic test_init_extremes();
        send_item(vakf_pkg::CMD_INIT, 32'hffff_ffff, 16'hffff, 32'h7fff_ffff, 32'h8000_0000);
        send_item(vakf_pkg::CMD_INIT, 32'h0, 16'h0, 32'h8000_0000, 32'h7fff_ffff);
        send_item(CMD_UNUSED, 32'h1234, 16'h10, 32'h0, 32'h0);
    endtask

    task automatic test_predict_extremes();
        send_item(vakf_pkg::CMD_PREDICT, 32'h7fff_ffff, 16'hffff, 32'h0, 32'h0);
        send_item(vakf_pkg::CMD_PREDICT, 32'h8000_0000, 16'hffff, 32'h0, 32'h0);
        send_item(vakf_pkg::CMD_PREDICT, 32'h8000_0000, 16'h0, 32'h0, 32'h0);
        write_reg(vakf_pkg::CFG_ACCEL_VAR, 32'hffff_ffff);
        send_item(vakf_pkg::CMD_INIT, 32'h0, 16'h0, 32'h7fff_0000, 32'h7fff_0000);
        send_item(vakf_pkg::CMD_PREDICT, 32'h7fff_ffff, 16'hffff, 32'h0, 32'h0);
        send_item(vakf_pkg::CMD_PREDICT, 32'h7fff_ffff, 16'hffff, 32'h0, 32'h0);
        send_item(vakf_pkg::CMD_BARO, 32'h0, 16'h0, 32'h8000_0000, 32'h0);
        write_reg(vakf_pkg::CFG_ACCEL_VAR, 32'h0);
        send_item(vakf_pkg::CMD_PREDICT, 32'h0000_8000, 16'h0001, 32'h0, 32'h0);
    endtask

    // Zero measurement noise drives cov_hh to zero, so the next update is skipped.
    task automatic test_baro_and_skip();
        write_reg(vakf_pkg::CFG_BARO_VAR, 32'h0);
        send_item(vakf_pkg::CMD_INIT, 32'h0, 16'h0, 32'h0001_0000, 32'h0);
        send_item(vakf_pkg::CMD_BARO, 32'h0, 16'h0, 32'h0003_0000, 32'h0);
        send_item(vakf_pkg::CMD_BARO, 32'h0, 16'h0, 32'h7fff_ffff, 32'h0);
        send_item(vakf_pkg::CMD_PREDICT, 32'h0, 16'h0, 32'h0, 32'h0);
        send_item(vakf_pkg::CMD_BARO, 32'h0, 16'h0, 32'h8000_0000, 32'h0);
        write_reg(vakf_pkg::CFG_BARO_VAR, 32'hffff_ffff);
        send_item(vakf_pkg::CMD_INIT, 32'h0, 16'h0, 32'h0, 32'h0);
        send_item(vakf_pkg::CMD_BARO, 32'h0, 16'h0, 32'h7fff_ffff, 32'h0);
        // Pause the sender until every estimate has come back.
        drain();
        send_item(vakf_pkg::CMD_BARO, 32'h0, 16'h0, 32'h8000_0000, 32'h0);
    endtask

    function automatic logic [31:0] pick_var();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    // Random tracks: an initialize, then a run of predicts, baro updates and the odd unused command.
    task automatic test_random_tracks();
        vakf_pkg::t_cmd cmd;
        int r, sent;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(vakf_pkg::CFG_ACCEL_VAR, pick_var());
            write_reg(vakf_pkg::CFG_BARO_VAR, pick_var());
            idle_off = (ph == 3);
            sent = 0;
            while (sent < 210) begin
                send_item(vakf_pkg::CMD_INIT, $urandom, 16'($urandom),
                          $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 32'h00ff_ffff),
                          $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 32'h000f_ffff));
                sent++;
                repeat ($urandom_range(2, 30)) begin
                    r = $urandom_range(0, 99);
                    cmd = r < 55 ? vakf_pkg::CMD_PREDICT
                                 : (r < 95 ? vakf_pkg::CMD_BARO : CMD_UNUSED);
                    send_item(cmd,
                              $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 32'h001f_ffff)
                                  - 32'h0010_0000,
                              16'($urandom_range(0, 3) == 0 ? $urandom
                                                            : $urandom_range(0, 16'h1000)),
                              $urandom_range(0, 7) == 0 ? $urandom : est_h[31:0]
                                  + $urandom_range(0, 32'h0007_ffff) - 32'h0004_0000,
                              $urandom);
                    sent++;
                end
            end
        end
        idle_off = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        accel_var = vakf_pkg::VAR_RESET;
        baro_var = vakf_pkg::VAR_RESET;
        reset_filter_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_init_extremes();
        test_predict_extremes();
        test_baro_and_skip();
        test_random_tracks();

        drain();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && estimate_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #60ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
